FILE: design/nns_pkg.sv
// Shared types, codes and helper functions for the nearest-neighbor image scaler.
`timescale 1ns / 1ps
`default_nettype none
package nns_pkg;

   localparam int COORD_W    = 14;
   localparam int PIXEL_W    = 32;
   localparam int DIM_W      = 9;
   localparam int FACTOR_W   = 16;
   localparam int SCALED_W   = 12;
   localparam int PROD_W     = DIM_W + FACTOR_W;
   localparam int DIVIDEND_W = COORD_W + 12;
   localparam int DIVISOR_W  = SCALED_W;
   localparam int QUOT_W     = FACTOR_W;
   localparam int STEP_W     = $clog2(QUOT_W);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int LIMIT_W    = 13;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_SRC_WIDTH    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SRC_HEIGHT   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_FACTOR = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIT_TO_BOX   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOX_WIDTH    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOX_HEIGHT   = 3'd5;

   localparam logic [FACTOR_W-1:0] FACTOR_MAX = 16'hFFFF;
   localparam logic [SCALED_W-1:0] SCALED_MAX = 12'hFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIT_W_GO,
      ST_FIT_W_RUN,
      ST_FIT_H_GO,
      ST_FIT_H_RUN,
      ST_MUL_W,
      ST_MUL_H,
      ST_CHECK,
      ST_MUL_X,
      ST_DIV_X_GO,
      ST_DIV_X_RUN,
      ST_DIV_Y_GO,
      ST_DIV_Y_RUN,
      ST_READ,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [DIM_W-1:0]    src_w;
      logic [DIM_W-1:0]    src_h;
      logic [FACTOR_W-1:0] factor;
      logic                fit;
      logic [COORD_W-1:0]  box_w;
      logic [COORD_W-1:0]  box_h;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [LIMIT_W-1:0] lim);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if ({{(LIMIT_W-DIM_W){1'b0}}, v} > lim) begin
         r = lim[DIM_W-1:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [SCALED_W-1:0] sat_scaled(input logic [PROD_W-1:0] p);
      logic [SCALED_W-1:0] r;
      if (p[PROD_W-1]) begin
         r = SCALED_MAX;
      end else begin
         r = p[PROD_W-2:12];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/nns_intf.sv
// Handshake interfaces for the request, response and register write channels.
`timescale 1ns / 1ps
`default_nettype none
interface nns_req_if;
   import nns_pkg::*;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [COORD_W-1:0] coord_x;
   logic [COORD_W-1:0] coord_y;
   logic [PIXEL_W-1:0] pixel_in;
   modport source (output valid, kind, coord_x, coord_y, pixel_in, input ready);
   modport sink (input valid, kind, coord_x, coord_y, pixel_in, output ready);
endinterface

interface nns_rsp_if;
   import nns_pkg::*;
   logic                valid;
   logic                ready;
   logic [PIXEL_W-1:0]  pixel_out;
   logic                in_range;
   logic [SCALED_W-1:0] scaled_width;
   logic [SCALED_W-1:0] scaled_height;
   modport source (output valid, pixel_out, in_range, scaled_width, scaled_height,
                   input ready);
   modport sink (input valid, pixel_out, in_range, scaled_width, scaled_height,
                 output ready);
endinterface

interface nns_csr_if;
   import nns_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

FILE: design/nns_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module nns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: design/nns_div.sv
// Restoring divider that produces one quotient bit per cycle, most significant first.
`timescale 1ns / 1ps
`default_nettype none
module nns_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [nns_pkg::DIVIDEND_W-1:0]   dividend,
   input  wire logic [nns_pkg::DIVISOR_W-1:0]    divisor,
   output logic      [nns_pkg::QUOT_W-1:0]       quotient,
   output nns_pkg::div_stat_type                 status
);
   import nns_pkg::*;

   localparam int SHIFT_W = DIVISOR_W + QUOT_W - 1;
   localparam int TRIAL_W = DIVIDEND_W + 2;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic [SHIFT_W-1:0]    shifted;
   logic [TRIAL_W-1:0]    trial;
   logic                  fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   always_comb begin
      shifted = SHIFT_W'(dvs_ff) << step_ff;
      trial   = {2'b00, rem_ff} - {{(TRIAL_W-SHIFT_W){1'b0}}, shifted};
      fits    = ~trial[TRIAL_W-1];
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QUOT_W - 1);
         rem_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         if (fits) begin
            rem_in = trial[DIVIDEND_W-1:0];
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

`ifndef SYNTH
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && step_ff == '0 |=> done_ff) else $error("divider missed done");
`endif
endmodule
`default_nettype wire

FILE: design/nns_csr.sv
// Configuration registers with source size clamping.
`timescale 1ns / 1ps
`default_nettype none
module nns_csr #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   nns_csr_if.sink         csr_chan,
   output nns_pkg::cfg_type cfg
);
   import nns_pkg::*;

   logic [DIM_W-1:0]    src_w_ff;
   logic [DIM_W-1:0]    src_h_ff;
   logic [FACTOR_W-1:0] factor_ff;
   logic                fit_ff;
   logic [COORD_W-1:0]  box_w_ff;
   logic [COORD_W-1:0]  box_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff  <= DIM_W'(256);
         src_h_ff  <= DIM_W'(256);
         factor_ff <= FACTOR_W'(4096);
         fit_ff    <= 1'b0;
         box_w_ff  <= COORD_W'(256);
         box_h_ff  <= COORD_W'(256);
      end else if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            CSR_SRC_WIDTH:    src_w_ff  <= csr_chan.data[DIM_W-1:0];
            CSR_SRC_HEIGHT:   src_h_ff  <= csr_chan.data[DIM_W-1:0];
            CSR_SCALE_FACTOR: factor_ff <= csr_chan.data[FACTOR_W-1:0];
            CSR_FIT_TO_BOX:   fit_ff    <= csr_chan.data[0];
            CSR_BOX_WIDTH:    box_w_ff  <= csr_chan.data[COORD_W-1:0];
            CSR_BOX_HEIGHT:   box_h_ff  <= csr_chan.data[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;
   assign cfg.src_w      = clamp_dim(src_w_ff, LIMIT_W'(MAX_WIDTH));
   assign cfg.src_h      = clamp_dim(src_h_ff, LIMIT_W'(MAX_HEIGHT));
   assign cfg.factor     = factor_ff;
   assign cfg.fit        = fit_ff;
   assign cfg.box_w      = box_w_ff;
   assign cfg.box_h      = box_h_ff;
endmodule
`default_nettype wire

FILE: design/nearest_neighbor_image_scaler.sv
// Top level: nearest-neighbor scaler with a sequencer around one shared multiplier and divider.
// A load beat is accepted while the sequencer is idle, and loads can follow back to back.
// A fetch inside the scaled image has its response after two passes through the 16-step shared
// serial divider; outside it, both divisions are skipped. The next beat can be accepted in the
// cycle the response is presented. Fit mode adds up to two divider passes; a held response stalls.
// Synchronous reset restores the register defaults; the pixel store is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbor_image_scaler #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   nns_req_if.sink   req_chan,
   nns_rsp_if.source rsp_chan,
   nns_csr_if.sink   csr_chan
);
   import nns_pkg::*;

   localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW    = XW + YW;
   localparam int DEPTH = 1 << AW;

   cfg_type      cfg;
   div_stat_type div_stat;

   state_type           state_ff, state_in;
   logic [COORD_W-1:0]  x_ff, x_in;
   logic [COORD_W-1:0]  y_ff, y_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [FACTOR_W-1:0] fw_ff, fw_in;
   logic [SCALED_W-1:0] ow_ff, ow_in;
   logic [SCALED_W-1:0] oh_ff, oh_in;
   logic                inside_ff, inside_in;
   logic [DIM_W-1:0]    sx_ff, sx_in;
   logic [DIM_W-1:0]    sy_ff, sy_in;
   logic [PROD_W-1:0]   mul_ff, mul_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic                rsp_in_range_ff, rsp_in_range_in;
   logic [SCALED_W-1:0] rsp_sw_ff, rsp_sw_in;
   logic [SCALED_W-1:0] rsp_sh_ff, rsp_sh_in;

   logic [DIM_W-1:0]      mul_a;
   logic [FACTOR_W-1:0]   mul_b;
   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [QUOT_W-1:0]     div_q;
   logic                  req_fire;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [PIXEL_W-1:0]    ram_rd_data;

   nns_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   nns_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .status   (div_stat)
   );

   nns_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_chan.pixel_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign ram_wr_en      = req_fire && (req_chan.kind == KIND_LOAD)
                           && (req_chan.coord_x < {{(COORD_W-DIM_W){1'b0}}, cfg.src_w})
                           && (req_chan.coord_y < {{(COORD_W-DIM_W){1'b0}}, cfg.src_h});
   assign ram_wr_addr    = {YW'(req_chan.coord_y), XW'(req_chan.coord_x)};
   assign ram_rd_en      = (state_ff == ST_READ);
   assign ram_rd_addr    = {YW'(sy_ff), XW'(sx_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      y_ff            <= y_in;
      factor_ff       <= factor_in;
      fw_ff           <= fw_in;
      ow_ff           <= ow_in;
      oh_ff           <= oh_in;
      inside_ff       <= inside_in;
      sx_ff           <= sx_in;
      sy_ff           <= sy_in;
      mul_ff          <= mul_in;
      rsp_pixel_ff    <= rsp_pixel_in;
      rsp_in_range_ff <= rsp_in_range_in;
      rsp_sw_ff       <= rsp_sw_in;
      rsp_sh_ff       <= rsp_sh_in;
   end

   always_comb begin
      state_in        = state_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      factor_in       = factor_ff;
      fw_in           = fw_ff;
      ow_in           = ow_ff;
      oh_in           = oh_ff;
      inside_in       = inside_ff;
      sx_in           = sx_ff;
      sy_in           = sy_ff;
      mul_in          = mul_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_pixel_in    = rsp_pixel_ff;
      rsp_in_range_in = rsp_in_range_ff;
      rsp_sw_in       = rsp_sw_ff;
      rsp_sh_in       = rsp_sh_ff;
      mul_a           = cfg.src_w;
      mul_b           = factor_ff;
      div_start       = 1'b0;
      div_dividend    = {cfg.box_w, 12'b0};
      div_divisor     = DIVISOR_W'(cfg.src_w);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_chan.kind == KIND_FETCH) begin
               x_in      = req_chan.coord_x;
               y_in      = req_chan.coord_y;
               factor_in = cfg.factor;
               state_in  = cfg.fit ? ST_FIT_W_GO : ST_MUL_W;
            end
         end
         ST_FIT_W_GO: begin
            if (cfg.box_w >= {1'b0, cfg.src_w, 4'b0}) begin
               fw_in    = FACTOR_MAX;
               state_in = ST_FIT_H_GO;
            end else begin
               div_start = 1'b1;
               state_in  = ST_FIT_W_RUN;
            end
         end
         ST_FIT_W_RUN: begin
            if (div_stat.done) begin
               fw_in    = div_q;
               state_in = ST_FIT_H_GO;
            end
         end
         ST_FIT_H_GO: begin
            div_dividend = {cfg.box_h, 12'b0};
            div_divisor  = DIVISOR_W'(cfg.src_h);
            if (cfg.box_h >= {1'b0, cfg.src_h, 4'b0}) begin
               factor_in = fw_ff;
               state_in  = ST_MUL_W;
            end else begin
               div_start = 1'b1;
               state_in  = ST_FIT_H_RUN;
            end
         end
         ST_FIT_H_RUN: begin
            if (div_stat.done) begin
               factor_in = (div_q < fw_ff) ? div_q : fw_ff;
               state_in  = ST_MUL_W;
            end
         end
         ST_MUL_W: begin
            mul_in   = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in = ST_MUL_H;
         end
         ST_MUL_H: begin
            mul_a    = cfg.src_h;
            ow_in    = sat_scaled(mul_ff);
            mul_in   = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            oh_in    = sat_scaled(mul_ff);
            state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            mul_b     = FACTOR_W'(x_ff);
            mul_in    = PROD_W'(mul_a) * PROD_W'(mul_b);
            inside_in = (x_ff < COORD_W'(ow_ff)) && (y_ff < COORD_W'(oh_ff));
            state_in  = inside_in ? ST_DIV_X_GO : ST_OUT;
         end
         ST_DIV_X_GO: begin
            div_dividend = DIVIDEND_W'(mul_ff);
            div_divisor  = ow_ff;
            div_start    = 1'b1;
            mul_a        = cfg.src_h;
            mul_b        = FACTOR_W'(y_ff);
            mul_in       = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in     = ST_DIV_X_RUN;
         end
         ST_DIV_X_RUN: begin
            if (div_stat.done) begin
               sx_in    = div_q[DIM_W-1:0];
               state_in = ST_DIV_Y_GO;
            end
         end
         ST_DIV_Y_GO: begin
            div_dividend = DIVIDEND_W'(mul_ff);
            div_divisor  = oh_ff;
            div_start    = 1'b1;
            state_in     = ST_DIV_Y_RUN;
         end
         ST_DIV_Y_RUN: begin
            if (div_stat.done) begin
               sy_in    = div_q[DIM_W-1:0];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_pixel_in    = inside_ff ? ram_rd_data : '0;
               rsp_in_range_in = inside_ff;
               rsp_sw_in       = ow_ff;
               rsp_sh_in       = oh_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pixel_out     = rsp_pixel_ff;
   assign rsp_chan.in_range      = rsp_in_range_ff;
   assign rsp_chan.scaled_width  = rsp_sw_ff;
   assign rsp_chan.scaled_height = rsp_sh_ff;

`ifndef SYNTH
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy) else $error("divider started while busy");
   a_sx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_X_RUN && div_stat.done |-> div_q < QUOT_W'(cfg.src_w))
      else $error("source column beyond source width");
   a_sy_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_Y_RUN && div_stat.done |-> div_q < QUOT_W'(cfg.src_h))
      else $error("source row beyond source height");
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_in_range_ff |-> rsp_pixel_ff == '0)
      else $error("pixel not cleared outside the scaled image");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff == ST_IDLE) else $error("store written during a fetch");
`endif
endmodule
`default_nettype wire
